>>> hw/rtl/cmvm_pkg.sv
// shared types, constants and rounding function for the complex matrix-vector multiplier
package cmvm_pkg;

  localparam int MAX_DIM   = 16;
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int ADDR_W    = 2 * DIM_W;
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 14;
  localparam int DIM_CFG_W = 5;
  localparam int REQ_W     = 2;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int ACC_W     = SUM_W + DIM_W;

  localparam logic [REQ_W-1:0] REQ_WR_MAT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_VEC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MUL    = 2'd2;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = DIM_CFG_W'(MAX_DIM);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic last;
  } cmac_ctl_t;

  typedef struct packed {
    logic done;
  } cmac_sts_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              clip;
  } rs_t;

  function automatic rs_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    rs_t                     res;
    r = acc + (ACC_W'(1) << (FRAC_BITS - 1));
    q = r >>> FRAC_BITS;
    res.clip = 1'b0;
    if (q > SAT_HI) begin
      q        = SAT_HI;
      res.clip = 1'b1;
    end else if (q < SAT_LO) begin
      q        = SAT_LO;
      res.clip = 1'b1;
    end
    res.val = q[DATA_W-1:0];
    return res;
  endfunction

endpackage

>>> hw/rtl/cmvm_if.sv
// request and result channel interfaces
interface cmvm_req_if import cmvm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic [DIM_W-1:0]         row;
  logic [DIM_W-1:0]         col;
  logic signed [DATA_W-1:0] value_real;
  logic signed [DATA_W-1:0] value_imag;

  modport source (output valid, req_type, row, col, value_real, value_imag, input ready);
  modport sink   (input valid, req_type, row, col, value_real, value_imag, output ready);
endinterface

interface cmvm_res_if import cmvm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [DIM_W-1:0]         out_index;
  logic signed [DATA_W-1:0] out_real;
  logic signed [DATA_W-1:0] out_imag;
  logic                     saturated;
  logic                     last;

  modport source (output valid, out_index, out_real, out_imag, saturated, last, input ready);
  modport sink   (input valid, out_index, out_real, out_imag, saturated, last, output ready);
endinterface

>>> hw/rtl/complex_matrix_vector_multiply.sv
// top level of the complex matrix-vector multiplier
// load transactions: one per cycle while idle, no result
// compute transaction: n = clamped dimension rows, one complex mac per cycle within a row;
//   each row runs through the shared mac pipeline and then waits until its result is taken
// not ready from compute acceptance until the last row's result is taken
// reset: idle, dimension 16; matrix and vector stores hold no reset value
module complex_matrix_vector_multiply import cmvm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  cmvm_req_if.sink             in_ch,
  cmvm_res_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [DIM_CFG_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAC  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIM_CFG_W-1:0]    dim_r;
  logic [DIM_W-1:0]        i_r, i_nxt;
  logic [DIM_W-1:0]        j_r, j_nxt;
  logic [DIM_W-1:0]        n_last_r, n_last_nxt;
  logic                    issue_done_r, issue_done_nxt;
  logic [DIM_W-1:0]        dim_last;

  cplx_t                   mat_mem [MAT_DEPTH];
  cplx_t                   vec_mem [MAX_DIM];
  cplx_t                   mat_rd_r, vec_rd_r;

  logic                    in_acc, wr_mat, wr_vec, start_mul, issue, out_acc, row_clear;
  cmac_ctl_t               mac_ctl;
  cmac_sts_t               mac_sts;
  logic signed [ACC_W-1:0] acc_re, acc_im;
  rs_t                     rs_re, rs_im;

  logic [DIM_W-1:0]        out_index_r;
  logic [DATA_W-1:0]       out_real_r, out_imag_r;
  logic                    sat_r, last_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign wr_mat      = in_acc & (in_ch.req_type == REQ_WR_MAT);
  assign wr_vec      = in_acc & (in_ch.req_type == REQ_WR_VEC);
  assign start_mul   = in_acc & (in_ch.req_type == REQ_MUL);
  assign issue       = (state_r == S_MAC) & ~issue_done_r;
  assign out_acc     = out_ch.valid & out_ch.ready;
  assign row_clear   = start_mul | (out_acc & ~last_r);

  always_comb begin
    if (dim_r == '0) begin
      dim_last = '0;
    end else if (dim_r > DIM_CFG_W'(MAX_DIM)) begin
      dim_last = DIM_W'(MAX_DIM - 1);
    end else begin
      dim_last = DIM_W'(dim_r - 1'b1);
    end
  end

  // stores
  always_ff @(posedge clk) begin
    if (wr_mat) begin
      mat_mem[{in_ch.row, in_ch.col}] <= {in_ch.value_real, in_ch.value_imag};
    end
    if (issue) begin
      mat_rd_r <= mat_mem[{i_r, j_r}];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_vec) begin
      vec_mem[in_ch.row] <= {in_ch.value_real, in_ch.value_imag};
    end
    if (issue) begin
      vec_rd_r <= vec_mem[j_r];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    n_last_nxt     = n_last_r;
    issue_done_nxt = issue_done_r;
    case (state_r)
      S_IDLE: begin
        if (start_mul) begin
          state_nxt      = S_MAC;
          i_nxt          = '0;
          j_nxt          = '0;
          n_last_nxt     = dim_last;
          issue_done_nxt = 1'b0;
        end
      end
      S_MAC: begin
        if (issue) begin
          j_nxt = j_r + DIM_W'(1);
          if (j_r == n_last_r) begin
            issue_done_nxt = 1'b1;
          end
        end
        if (mac_sts.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt      = S_MAC;
            i_nxt          = i_r + DIM_W'(1);
            j_nxt          = '0;
            issue_done_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      dim_r        <= DIM_RESET;
      i_r          <= '0;
      j_r          <= '0;
      n_last_r     <= '0;
      issue_done_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      n_last_r     <= n_last_nxt;
      issue_done_r <= issue_done_nxt;
      if (cfg_we) begin
        dim_r <= cfg_wdata;
      end
    end
  end

  // one mac per cycle while a row is issued; the data read is registered and reaches the mac in the cycle after issue
  logic issue_d_r, issue_last_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_d_r      <= 1'b0;
      issue_last_d_r <= 1'b0;
    end else begin
      issue_d_r      <= issue;
      issue_last_d_r <= issue & (j_r == n_last_r);
    end
  end

  assign mac_ctl.clear = row_clear;
  assign mac_ctl.valid = issue_d_r;
  assign mac_ctl.last  = issue_last_d_r;

  cmvm_cmac u_cmac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a      (mat_rd_r),
    .b      (vec_rd_r),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .sts    (mac_sts)
  );

  assign rs_re = round_sat(acc_re);
  assign rs_im = round_sat(acc_im);

  // result register
  always_ff @(posedge clk) begin
    if (mac_sts.done) begin
      out_index_r <= i_r;
      out_real_r  <= rs_re.val;
      out_imag_r  <= rs_im.val;
      sat_r       <= rs_re.clip | rs_im.clip;
      last_r      <= (i_r == n_last_r);
    end
  end

  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.out_index = out_index_r;
  assign out_ch.out_real  = out_real_r;
  assign out_ch.out_imag  = out_imag_r;
  assign out_ch.saturated = sat_r;
  assign out_ch.last      = last_r;

endmodule

>>> hw/rtl/cmvm_cmac.sv
// pipelined complex multiply-accumulate unit shared by all rows
module cmvm_cmac import cmvm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmac_ctl_t                ctl,
  input  cplx_t                    a,
  input  cplx_t                    b,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im,
  output cmac_sts_t                sts
);

  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [SUM_W-1:0]  s_re_r, s_im_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic                     v1_r, l1_r, v2_r, l2_r, done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      l1_r   <= 1'b0;
      v2_r   <= 1'b0;
      l2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= ctl.valid;
      l1_r   <= ctl.valid & ctl.last;
      v2_r   <= v1_r;
      l2_r   <= l1_r;
      done_r <= v2_r & l2_r;
    end
  end

  // products, combine, accumulate
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      p_rr_r <= a.re * b.re;
      p_ii_r <= a.im * b.im;
      p_ri_r <= a.re * b.im;
      p_ir_r <= a.im * b.re;
    end
    if (v1_r) begin
      s_re_r <= SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
      s_im_r <= SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
    end
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + ACC_W'(s_re_r);
      acc_im_r <= acc_im_r + ACC_W'(s_im_r);
    end
  end

  assign acc_re   = acc_re_r;
  assign acc_im   = acc_im_r;
  assign sts.done = done_r;

endmodule

>>> hw/rtl/cmvm_checker.sv
// port-level assertions for the complex matrix-vector multiplier
module cmvm_checker import cmvm_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [REQ_W-1:0]         in_req_type,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [DIM_W-1:0]         out_index,
  input logic signed [DATA_W-1:0] out_real,
  input logic                     out_last
);

  // busy while a result is shown
  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // compute transaction blocks the input
  a_mul_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_MUL) |=> !in_ready)
    else $error("ready right after a compute transaction");

  // no result right after the last one
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result after the last row");

  // stalled result holds its valid, index and real part
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_index) && $stable(out_real)))
    else $error("stalled result changed");

endmodule

bind complex_matrix_vector_multiply cmvm_checker u_cmvm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_index   (out_ch.out_index),
  .out_real    (out_ch.out_real),
  .out_last    (out_ch.last)
);
